// ===== rtl/one_wire_temperature_reader_unit_defines.svh =====
// Assertion macros used by the one-wire temperature reader checker.
`ifndef ONE_WIRE_TEMPERATURE_READER_UNIT_DEFINES_SVH
`define ONE_WIRE_TEMPERATURE_READER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define OWTR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("owtr assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define OWTR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("owtr assertion failed");

`endif

// ===== rtl/owtr_pkg.sv =====
// Types and constants of the one-wire temperature reader.
`timescale 1ns / 1ps
package owtr_pkg;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_SAMPLE,
		PH_RST_REC,
		PH_WR_LOW,
		PH_WR_REL,
		PH_RD_LOW,
		PH_RD_SAMPLE,
		PH_RD_REC,
		PH_CONV_WAIT
	} phase_t;

	// Position in the command sequence.
	typedef enum logic [2:0] {
		STEP_FIRST_RESET,
		STEP_SKIP_ROM_1,
		STEP_CONVERT,
		STEP_SECOND_RESET,
		STEP_SKIP_ROM_2,
		STEP_READ_CMD,
		STEP_READ_LSB,
		STEP_READ_MSB
	} byte_step_t;

	typedef enum logic [0:0] {
		REG_RETRY_LIMIT,
		REG_CONV_WAIT
	} cfg_reg_t;

	typedef struct packed {
		logic               drive_low;
		logic               done_res;
		logic               failed;
		logic signed [15:0] temperature;
	} result_t;

	localparam int TIMER_W = 20;
	localparam int RETRY_W = 16;

	localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
	localparam logic [7:0] CMD_CONVERT_T    = 8'h44;
	localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
	localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

	localparam logic [TIMER_W-1:0] T_RST_LOW    = 20'd480;
	localparam logic [TIMER_W-1:0] T_RST_SAMPLE = 20'd70;
	localparam logic [TIMER_W-1:0] T_RST_REC    = 20'd410;
	localparam logic [TIMER_W-1:0] T_WR1_LOW    = 20'd6;
	localparam logic [TIMER_W-1:0] T_WR1_REL    = 20'd64;
	localparam logic [TIMER_W-1:0] T_WR0_LOW    = 20'd60;
	localparam logic [TIMER_W-1:0] T_WR0_REL    = 20'd10;
	localparam logic [TIMER_W-1:0] T_RD_LOW     = 20'd6;
	localparam logic [TIMER_W-1:0] T_RD_SAMPLE  = 20'd9;
	localparam logic [TIMER_W-1:0] T_RD_REC     = 20'd55;

	localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 16'd1000;
	localparam logic [TIMER_W-1:0] CONV_WAIT_RST   = 20'd94000;

endpackage

// ===== rtl/one_wire_temperature_reader_unit.sv =====
// One-wire master that reads one temperature conversion from a DS18B20.
`timescale 1ns / 1ps
// Takes one transaction per clock while in_stall is low: each carries the
// microsecond tick, the sampled bus level and a start request, and yields one
// result transaction with the bus drive, a done flag, a no-presence flag and
// the signed raw temperature in 1/16 degree. The sequencer state updates in the
// cycle the transaction is accepted; its result enters the result register, or
// the skid register while that is held; the two entries let input keep flowing
// while a result waits, so in_stall rises only when both entries are full.
// A full read spans the slot timings and conv_wait_q, counted in tick microseconds.
module one_wire_temperature_reader_unit
	import owtr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               tick,
	input  logic               bus_level,
	input  logic               start_req,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               drive_low,
	output logic               done_res,
	output logic               failed,
	output logic signed [15:0] temperature
);

	logic [RETRY_W-1:0] retry_limit_q;
	logic [TIMER_W-1:0] conv_wait_q;
	cfg_reg_t           cfg_sel;
	logic               cfg_wr;

	phase_t             phase_q, phase_d;
	byte_step_t         step_q, step_d;
	logic [TIMER_W-1:0] timer_q, timer_d, timer_inc, seg_len;
	logic [2:0]         bit_q, bit_d, bit_inc;
	logic [7:0]         shift_q, shift_d;
	logic [15:0]        value_q, value_d;
	logic [RETRY_W-1:0] retry_q, retry_d, retry_inc;
	logic               presence_q, presence_d;

	result_t            res_d, main_q, skid_q;
	logic               main_valid_q, skid_valid_q;
	logic               in_fire, out_fire;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_sel = cfg_reg_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		case (cfg_sel)
			REG_RETRY_LIMIT: prdata = {16'd0, retry_limit_q};
			REG_CONV_WAIT:   prdata = {12'd0, conv_wait_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RST;
			conv_wait_q   <= CONV_WAIT_RST;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_RETRY_LIMIT: retry_limit_q <= pwdata[RETRY_W-1:0];
				REG_CONV_WAIT:   conv_wait_q   <= pwdata[TIMER_W-1:0];
				default:         ;
			endcase
		end
	end

	// Handshake
	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = main_valid_q && !out_stall;

	// Sequencer
	assign timer_inc = (tick && timer_q != TIMER_MAX) ? timer_q + 1'b1 : timer_q;
	assign retry_inc = (retry_q != RETRY_MAX) ? retry_q + 1'b1 : retry_q;
	assign bit_inc   = bit_q + 3'd1;

	always_comb begin
		case (phase_q)
			PH_RST_LOW:    seg_len = T_RST_LOW;
			PH_RST_SAMPLE: seg_len = T_RST_SAMPLE;
			PH_RST_REC:    seg_len = T_RST_REC;
			PH_WR_LOW:     seg_len = shift_q[0] ? T_WR1_LOW : T_WR0_LOW;
			PH_WR_REL:     seg_len = shift_q[0] ? T_WR1_REL : T_WR0_REL;
			PH_RD_LOW:     seg_len = T_RD_LOW;
			PH_RD_SAMPLE:  seg_len = T_RD_SAMPLE;
			PH_RD_REC:     seg_len = T_RD_REC;
			PH_CONV_WAIT:  seg_len = conv_wait_q;
			default:       seg_len = '0;
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		step_d     = step_q;
		timer_d    = timer_q;
		bit_d      = bit_q;
		shift_d    = shift_q;
		value_d    = value_q;
		retry_d    = retry_q;
		presence_d = presence_q;
		res_d      = '0;

		if (phase_q == PH_IDLE) begin
			if (start_req) begin
				step_d     = STEP_FIRST_RESET;
				retry_d    = '0;
				presence_d = 1'b0;
				bit_d      = '0;
				shift_d    = '0;
				value_d    = '0;
				timer_d    = '0;
				phase_d    = PH_RST_LOW;
			end
		end else begin
			timer_d = timer_inc;
			if (timer_inc >= seg_len) begin
				timer_d = '0;
				case (phase_q)
					PH_RST_LOW: begin
						phase_d = PH_RST_SAMPLE;
					end
					PH_RST_SAMPLE: begin
						presence_d = !bus_level;
						phase_d    = PH_RST_REC;
					end
					PH_RST_REC: begin
						if (presence_q) begin
							step_d  = (step_q == STEP_FIRST_RESET) ? STEP_SKIP_ROM_1
								: STEP_SKIP_ROM_2;
							shift_d = CMD_SKIP_ROM;
							bit_d   = '0;
							phase_d = PH_WR_LOW;
						end else if (step_q == STEP_FIRST_RESET) begin
							retry_d = retry_inc;
							if (retry_inc >= retry_limit_q) begin
								res_d.done_res = 1'b1;
								res_d.failed   = 1'b1;
								phase_d        = PH_IDLE;
							end else begin
								phase_d = PH_RST_LOW;
							end
						end else begin
							phase_d = PH_RST_LOW;
						end
					end
					PH_WR_LOW: begin
						phase_d = PH_WR_REL;
					end
					PH_WR_REL: begin
						shift_d = {1'b0, shift_q[7:1]};
						bit_d   = bit_inc;
						if (bit_inc != 3'd0) begin
							phase_d = PH_WR_LOW;
						end else if (step_q == STEP_SKIP_ROM_1) begin
							step_d  = STEP_CONVERT;
							shift_d = CMD_CONVERT_T;
							phase_d = PH_WR_LOW;
						end else if (step_q == STEP_CONVERT) begin
							phase_d = PH_CONV_WAIT;
						end else if (step_q == STEP_SKIP_ROM_2) begin
							step_d  = STEP_READ_CMD;
							shift_d = CMD_READ_SCRATCH;
							phase_d = PH_WR_LOW;
						end else begin
							step_d  = STEP_READ_LSB;
							shift_d = '0;
							phase_d = PH_RD_LOW;
						end
					end
					PH_CONV_WAIT: begin
						step_d     = STEP_SECOND_RESET;
						presence_d = 1'b0;
						phase_d    = PH_RST_LOW;
					end
					PH_RD_LOW: begin
						phase_d = PH_RD_SAMPLE;
					end
					PH_RD_SAMPLE: begin
						shift_d = {bus_level, shift_q[7:1]};
						phase_d = PH_RD_REC;
					end
					PH_RD_REC: begin
						bit_d = bit_inc;
						if (bit_inc != 3'd0) begin
							phase_d = PH_RD_LOW;
						end else if (step_q == STEP_READ_LSB) begin
							value_d = {8'd0, shift_q};
							step_d  = STEP_READ_MSB;
							phase_d = PH_RD_LOW;
						end else begin
							value_d           = {shift_q, value_q[7:0]};
							res_d.done_res    = 1'b1;
							res_d.temperature = signed'({shift_q, value_q[7:0]});
							phase_d           = PH_IDLE;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end

		res_d.drive_low = (phase_d == PH_RST_LOW) || (phase_d == PH_WR_LOW)
			|| (phase_d == PH_RD_LOW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			step_q     <= STEP_FIRST_RESET;
			timer_q    <= '0;
			bit_q      <= '0;
			shift_q    <= '0;
			value_q    <= '0;
			retry_q    <= '0;
			presence_q <= 1'b0;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			step_q     <= step_d;
			timer_q    <= timer_d;
			bit_q      <= bit_d;
			shift_q    <= shift_d;
			value_q    <= value_d;
			retry_q    <= retry_d;
			presence_q <= presence_d;
		end
	end

	// Result register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || out_fire) begin
			main_valid_q <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || out_fire) begin
			main_q <= skid_valid_q ? skid_q : res_d;
		end else if (in_fire) begin
			skid_q <= res_d;
		end
	end

	assign out_valid   = main_valid_q;
	assign drive_low   = main_q.drive_low;
	assign done_res    = main_q.done_res;
	assign failed      = main_q.failed;
	assign temperature = main_q.temperature;

endmodule

// ===== rtl/owtr_checker.sv =====
// Port-level checker for the one-wire temperature reader, bound to the top level.
`timescale 1ns / 1ps
`include "one_wire_temperature_reader_unit_defines.svh"
module owtr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               done_res,
	input logic               failed,
	input logic signed [15:0] temperature
);

	`OWTR_ASSERT_NOW(a_fail_has_done, out_valid && failed, done_res)
	`OWTR_ASSERT_NOW(a_fail_no_temp, out_valid && failed, temperature == 16'sd0)
	`OWTR_ASSERT_NEXT(a_skid_drains, in_stall && !out_stall, !in_stall)
	`OWTR_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(temperature))

endmodule

bind one_wire_temperature_reader_unit owtr_checker u_owtr_checker (.*);
